/* hdl/htfd_pkg.sv */
`default_nettype none

package htfd_pkg;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int WORD_W = 16;
    localparam int TEMP_W = 12;
    localparam int HUM_W  = 10;
    localparam int SER_W  = 32;
    localparam int POS_W  = 3;

    // Scaling datapath widths
    localparam int T_PROD_W = 31;   // 15-bit gain x 16-bit word
    localparam int H_PROD_W = 30;   // 14-bit gain x 16-bit word
    localparam int DIFF_W   = 19;   // signed difference after offset
    localparam int MAG_W    = 17;   // magnitude of that difference
    localparam int RECIP_W  = 18;
    localparam int DPROD_W  = MAG_W + RECIP_W;
    localparam int QUO_W    = 11;

    // CRC-8 settings
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

    // Conversion constants
    localparam logic [14:0]       T_GAIN       = 15'd21875;
    localparam logic [13:0]       H_GAIN       = 14'd15625;
    localparam int                SCALE_SHIFT  = 13;
    localparam logic [DIFF_W-1:0] T_OFFSET     = 19'd45000;
    localparam logic [DIFF_W-1:0] H_OFFSET     = 19'd6000;
    // floor(x * DIV100_RECIP / 2^DIV100_SHIFT) == floor(x / 100) for x < 2^17
    localparam logic [RECIP_W-1:0] DIV100_RECIP = 18'd167773;
    localparam int                 DIV100_SHIFT = 24;
    localparam logic [QUO_W-1:0]   HUM_MAX      = 11'd1000;

    // Place of the next byte in the reply frame
    typedef enum logic [POS_W-1:0] {
        POS_W0_HI = 3'd0,
        POS_W0_LO = 3'd1,
        POS_CRC0  = 3'd2,
        POS_W1_HI = 3'd3,
        POS_W1_LO = 3'd4,
        POS_CRC1  = 3'd5
    } t_pos;

    // Completed frame, handed from the frame tracker to the scaler
    typedef struct packed {
        logic              bus_fail;
        logic              crc0_bad;
        logic              crc1_bad;
        logic              serial;
        logic [WORD_W-1:0] w0;
        logic [WORD_W-1:0] w1;
    } t_frame;

    // Scaled values, handed from the scaler to the divider
    typedef struct packed {
        logic             bus_fail;
        logic             crc0_bad;
        logic             crc1_bad;
        logic             temp_keep;
        logic             temp_neg;
        logic [MAG_W-1:0] temp_mag;
        logic             hum_keep;
        logic             hum_neg;
        logic [MAG_W-1:0] hum_mag;
        logic [SER_W-1:0] serial_number;
    } t_scaled;

    // One byte of CRC-8, MSB first, no reflection
    function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* hdl/htfd_if.sv */
`default_nettype none

// Received reply bytes
interface htfd_in_if;
    logic                          valid;
    logic                          ready;
    logic [htfd_pkg::BYTE_W-1:0]   data_byte;
    logic                          mode;
    logic                          bus_error;

    modport source (output valid, data_byte, mode, bus_error, input ready);
    modport sink   (input valid, data_byte, mode, bus_error, output ready);
endinterface

// Decoded results
interface htfd_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [htfd_pkg::TEMP_W-1:0]   temperature_tenths;
    logic        [htfd_pkg::HUM_W-1:0]    humidity_tenths;
    logic        [htfd_pkg::SER_W-1:0]    serial_number;
    logic                                 bus_failed;
    logic                                 first_word_crc_bad;
    logic                                 second_word_crc_bad;

    modport source (output valid, temperature_tenths, humidity_tenths, serial_number,
                    bus_failed, first_word_crc_bad, second_word_crc_bad, input ready);
    modport sink   (input valid, temperature_tenths, humidity_tenths, serial_number,
                    bus_failed, first_word_crc_bad, second_word_crc_bad, output ready);
endinterface

`default_nettype wire

/* hdl/htfd_frame.sv */
`default_nettype none

module htfd_frame (
    input  logic             i_clk,
    input  logic             i_rst_n,
    htfd_in_if.sink          i_in,
    output htfd_pkg::t_frame o_rec,
    output logic             o_rec_valid,
    input  logic             i_rec_ready
);
    import htfd_pkg::*;

    t_pos              r_pos, n_pos;
    logic [BYTE_W-1:0] r_crc, n_crc;
    logic              r_first_ok, n_first_ok;
    logic              r_mode, n_mode;
    logic [WORD_W-1:0] r_w0, r_w1;
    t_frame            r_rec, n_rec;
    logic              r_rec_valid, n_rec_valid;

    logic              w_accept;
    logic              w_done;
    logic [BYTE_W-1:0] w_crc_next;

    // Take a beat whenever the frame record slot is free or draining
    assign i_in.ready = !r_rec_valid || i_rec_ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_crc_next = crc8_update(r_crc, i_in.data_byte);

    // Next frame position
    always_comb begin
        n_pos = r_pos;
        if (w_accept) begin
            if (i_in.bus_error) begin
                n_pos = POS_W0_HI;
            end else begin
                unique case (r_pos)
                    POS_W0_HI: n_pos = POS_W0_LO;
                    POS_W0_LO: n_pos = POS_CRC0;
                    POS_CRC0:  n_pos = POS_W1_HI;
                    POS_W1_HI: n_pos = POS_W1_LO;
                    POS_W1_LO: n_pos = POS_CRC1;
                    POS_CRC1:  n_pos = POS_W0_HI;
                    default:   n_pos = POS_W0_HI;
                endcase
            end
        end
    end

    // CRC, mode latch and frame completion
    always_comb begin
        n_crc      = r_crc;
        n_first_ok = r_first_ok;
        n_mode     = r_mode;
        w_done     = 1'b0;
        if (w_accept) begin
            if (i_in.bus_error) begin
                n_crc  = CRC_INIT;
                w_done = 1'b1;
            end else begin
                unique case (r_pos) inside
                    POS_W0_HI: begin
                        n_mode = i_in.mode;
                        n_crc  = w_crc_next;
                    end
                    POS_W0_LO, POS_W1_HI, POS_W1_LO: begin
                        n_crc = w_crc_next;
                    end
                    POS_CRC0: begin
                        n_first_ok = (r_crc == i_in.data_byte);
                        n_crc      = CRC_INIT;
                    end
                    POS_CRC1: begin
                        n_crc  = CRC_INIT;
                        w_done = 1'b1;
                    end
                    default: begin
                        n_crc = CRC_INIT;
                    end
                endcase
            end
        end
    end

    // Build the record for a finished or aborted frame
    always_comb begin
        n_rec = '0;
        if (i_in.bus_error) begin
            n_rec.bus_fail = 1'b1;
        end else begin
            n_rec.crc0_bad = !r_first_ok;
            n_rec.crc1_bad = (r_crc != i_in.data_byte);
            n_rec.serial   = r_mode;
            n_rec.w0       = r_w0;
            n_rec.w1       = r_w1;
        end
    end

    always_comb begin
        if (w_accept && w_done) begin
            n_rec_valid = 1'b1;
        end else if (i_rec_ready) begin
            n_rec_valid = 1'b0;
        end else begin
            n_rec_valid = r_rec_valid;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_W0_HI;
            r_crc       <= CRC_INIT;
            r_first_ok  <= 1'b0;
            r_mode      <= 1'b0;
            r_rec_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_first_ok  <= n_first_ok;
            r_mode      <= n_mode;
            r_rec_valid <= n_rec_valid;
        end
    end

    // Hold the data bytes and the outgoing record
    always_ff @(posedge i_clk) begin
        if (w_accept && !i_in.bus_error) begin
            case (r_pos)
                POS_W0_HI: r_w0[15:8] <= i_in.data_byte;
                POS_W0_LO: r_w0[7:0]  <= i_in.data_byte;
                POS_W1_HI: r_w1[15:8] <= i_in.data_byte;
                POS_W1_LO: r_w1[7:0]  <= i_in.data_byte;
                default: ;
            endcase
        end
        if (w_accept && w_done) begin
            r_rec <= n_rec;
        end
    end

    assign o_rec       = r_rec;
    assign o_rec_valid = r_rec_valid;

endmodule

`default_nettype wire

/* hdl/htfd_scale.sv */
`default_nettype none

module htfd_scale (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  htfd_pkg::t_frame  i_rec,
    input  logic              i_rec_valid,
    output logic              o_rec_ready,
    output htfd_pkg::t_scaled o_scl,
    output logic              o_scl_valid,
    input  logic              i_scl_ready
);
    import htfd_pkg::*;

    t_scaled             r_scl, n_scl;
    logic                r_valid;
    logic                w_load;
    logic [T_PROD_W-1:0] w_t_prod;
    logic [H_PROD_W-1:0] w_h_prod;
    logic [DIFF_W-1:0]   w_t_diff, w_h_diff;
    logic [DIFF_W-1:0]   w_t_abs, w_h_abs;
    logic                w_all_ok;

    assign o_rec_ready = !r_valid || i_scl_ready;
    assign w_load      = i_rec_valid && o_rec_ready;

    // Gain, shift and offset for both words
    assign w_t_prod = T_PROD_W'(T_GAIN) * T_PROD_W'(i_rec.w0);
    assign w_h_prod = H_PROD_W'(H_GAIN) * H_PROD_W'(i_rec.w1);
    assign w_t_diff = DIFF_W'(w_t_prod[T_PROD_W-1:SCALE_SHIFT]) - T_OFFSET;
    assign w_h_diff = DIFF_W'(w_h_prod[H_PROD_W-1:SCALE_SHIFT]) - H_OFFSET;

    // Split into sign and magnitude so the divider truncates toward zero
    assign w_t_abs = w_t_diff[DIFF_W-1] ? (DIFF_W'(0) - w_t_diff) : w_t_diff;
    assign w_h_abs = w_h_diff[DIFF_W-1] ? (DIFF_W'(0) - w_h_diff) : w_h_diff;

    assign w_all_ok = !i_rec.bus_fail && !i_rec.crc0_bad && !i_rec.crc1_bad;

    always_comb begin
        n_scl               = '0;
        n_scl.bus_fail      = i_rec.bus_fail;
        n_scl.crc0_bad      = i_rec.crc0_bad;
        n_scl.crc1_bad      = i_rec.crc1_bad;
        n_scl.temp_keep     = !i_rec.bus_fail && !i_rec.serial && !i_rec.crc0_bad;
        n_scl.temp_neg      = w_t_diff[DIFF_W-1];
        n_scl.temp_mag      = w_t_abs[MAG_W-1:0];
        n_scl.hum_keep      = !i_rec.bus_fail && !i_rec.serial && !i_rec.crc1_bad;
        n_scl.hum_neg       = w_h_diff[DIFF_W-1];
        n_scl.hum_mag       = w_h_abs[MAG_W-1:0];
        n_scl.serial_number = (i_rec.serial && w_all_ok) ? {i_rec.w0, i_rec.w1} : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_scl_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_scl <= n_scl;
        end
    end

    assign o_scl       = r_scl;
    assign o_scl_valid = r_valid;

endmodule

`default_nettype wire

/* hdl/htfd_div.sv */
`default_nettype none

module htfd_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  htfd_pkg::t_scaled i_scl,
    input  logic              i_scl_valid,
    output logic              o_scl_ready,
    htfd_out_if.source        o_out
);
    import htfd_pkg::*;

    logic               r_valid;
    logic [TEMP_W-1:0]  r_temp, n_temp;
    logic [HUM_W-1:0]   r_hum, n_hum;
    logic [SER_W-1:0]   r_serial;
    logic               r_bus_fail, r_crc0_bad, r_crc1_bad;
    logic               w_load;
    logic [DPROD_W-1:0] w_t_prod, w_h_prod;
    logic [QUO_W-1:0]   w_t_quo, w_h_quo;
    logic [TEMP_W-1:0]  w_t_ext;

    assign o_scl_ready = !r_valid || o_out.ready;
    assign w_load      = i_scl_valid && o_scl_ready;

    // Divide magnitudes by 100 through the reciprocal
    assign w_t_prod = DPROD_W'(i_scl.temp_mag) * DPROD_W'(DIV100_RECIP);
    assign w_h_prod = DPROD_W'(i_scl.hum_mag) * DPROD_W'(DIV100_RECIP);
    assign w_t_quo  = w_t_prod[DIV100_SHIFT +: QUO_W];
    assign w_h_quo  = w_h_prod[DIV100_SHIFT +: QUO_W];
    assign w_t_ext  = TEMP_W'(w_t_quo);

    // Restore the sign of temperature, zero on a bad word, a bus failure or a serial frame
    always_comb begin
        if (!i_scl.temp_keep) begin
            n_temp = '0;
        end else if (i_scl.temp_neg) begin
            n_temp = TEMP_W'(0) - w_t_ext;
        end else begin
            n_temp = w_t_ext;
        end
    end

    // Clamp humidity to the valid range, zero on a bad word, a bus failure or a serial frame
    always_comb begin
        if (!i_scl.hum_keep || i_scl.hum_neg) begin
            n_hum = '0;
        end else if (w_h_quo > HUM_MAX) begin
            n_hum = HUM_MAX[HUM_W-1:0];
        end else begin
            n_hum = w_h_quo[HUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Hold the result until the sink takes the beat
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_temp     <= n_temp;
            r_hum      <= n_hum;
            r_serial   <= i_scl.serial_number;
            r_bus_fail <= i_scl.bus_fail;
            r_crc0_bad <= i_scl.crc0_bad;
            r_crc1_bad <= i_scl.crc1_bad;
        end
    end

    assign o_out.valid               = r_valid;
    assign o_out.temperature_tenths  = $signed(r_temp);
    assign o_out.humidity_tenths     = r_hum;
    assign o_out.serial_number       = r_serial;
    assign o_out.bus_failed          = r_bus_fail;
    assign o_out.first_word_crc_bad  = r_crc0_bad;
    assign o_out.second_word_crc_bad = r_crc1_bad;

endmodule

`default_nettype wire

/* hdl/humidity_temp_frame_decoder.sv */
// Channel   Dir   Payload                                                  Beat
// i_in      in    data_byte[7:0], mode, bus_error                          one reply byte
// o_out     out   temperature_tenths[11:0], humidity_tenths[9:0],          one decoded frame
//                 serial_number[31:0], bus_failed, first/second crc flags
//
// One byte is taken per cycle while the frame tracker's record slot is free or draining.
// After the sixth byte (or a bus error beat) is taken, the result is registered in the
// frame tracker, then the scaling multiply, then the divide-by-100 register.
// Reset is synchronous, active low, and returns the tracker to the first byte.
// A stalled result holds in the output register.
`default_nettype none

module humidity_temp_frame_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    htfd_in_if.sink    i_in,
    htfd_out_if.source o_out
);
    import htfd_pkg::*;

    t_frame  w_rec;
    logic    w_rec_valid, w_rec_ready;
    t_scaled w_scl;
    logic    w_scl_valid, w_scl_ready;

    htfd_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_rec       (w_rec),
        .o_rec_valid (w_rec_valid),
        .i_rec_ready (w_rec_ready)
    );

    htfd_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (w_rec),
        .i_rec_valid (w_rec_valid),
        .o_rec_ready (w_rec_ready),
        .o_scl       (w_scl),
        .o_scl_valid (w_scl_valid),
        .i_scl_ready (w_scl_ready)
    );

    htfd_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_scl       (w_scl),
        .i_scl_valid (w_scl_valid),
        .o_scl_ready (w_scl_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

/* sim/humidity_temp_frame_decoder_tb.sv */
`timescale 1ns / 100ps

module humidity_temp_frame_decoder_tb;

    import htfd_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int STIM_ITEMS  = 450;
    localparam int TAIL_ITEMS  = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER  = 15;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT = 200000;

    // One reply byte as offered on the input channel
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              mode;
        logic              bus_error;
    } t_reply_beat;

    // One decoded frame as expected on the output channel
    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic [HUM_W-1:0]  hum;
        logic [SER_W-1:0]  serial;
        logic              bus_fail;
        logic              crc0_bad;
        logic              crc1_bad;
    } t_frame_result;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    htfd_in_if  in_ch ();
    htfd_out_if out_ch ();

    humidity_temp_frame_decoder i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    t_reply_beat   byte_q[$];
    t_frame_result expected_frames[$];

    // Decoder shadow state
    t_pos              dec_pos;
    logic [BYTE_W-1:0] dec_crc;
    logic [BYTE_W-1:0] dec_bytes [5];
    logic              dec_word0_ok;
    logic              dec_serial_mode;

    t_reply_beat   cur_beat;
    int            send_gap;
    int            recv_gap;
    int            hold_left;
    logic          hold_done;
    logic          quiet_tail;
    int            results_seen;
    int            error_count = 0;
    int            cycle_count;
    t_frame_result want;
    logic          rdy;

    // CRC-8, poly 0x31, MSB first
    function automatic logic [BYTE_W-1:0] crc8_fold(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        repeat (BYTE_W) begin
            c = c[BYTE_W-1] ? ({c[BYTE_W-2:0], 1'b0} ^ CRC_POLY) : {c[BYTE_W-2:0], 1'b0};
        end
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch on frame %0d: %s", $time, results_seen, msg);
        error_count++;
    endtask

    // Advance the shadow decoder by one accepted byte; queue a frame when one completes
    task automatic decode_beat(input t_reply_beat b);
        t_frame_result r;
        logic [WORD_W-1:0] w0;
        logic [WORD_W-1:0] w1;
        logic word1_ok;
        int unsigned prod;
        int t;
        int h;
        r = '0;
        if (b.bus_error) begin
            dec_pos = POS_W0_HI;
            dec_crc = CRC_INIT;
            r.bus_fail = 1'b1;
            expected_frames.push_back(r);
        end else begin
            if (dec_pos == POS_W0_HI) begin
                dec_serial_mode = b.mode;
            end
            case (dec_pos) inside
                POS_W0_HI, POS_W0_LO, POS_W1_HI, POS_W1_LO: begin
                    dec_bytes[dec_pos] = b.data_byte;
                    dec_crc = crc8_fold(dec_crc, b.data_byte);
                    dec_pos = t_pos'(dec_pos + 1);
                end
                POS_CRC0: begin
                    dec_bytes[POS_CRC0] = b.data_byte;
                    dec_word0_ok = (dec_crc == b.data_byte);
                    dec_crc = CRC_INIT;
                    dec_pos = POS_W1_HI;
                end
                default: begin
                    word1_ok = (dec_crc == b.data_byte);
                    dec_crc = CRC_INIT;
                    dec_pos = POS_W0_HI;
                    w0 = {dec_bytes[POS_W0_HI], dec_bytes[POS_W0_LO]};
                    w1 = {dec_bytes[POS_W1_HI], dec_bytes[POS_W1_LO]};
                    r.crc0_bad = !dec_word0_ok;
                    r.crc1_bad = !word1_ok;
                    if (dec_serial_mode) begin
                        if (dec_word0_ok && word1_ok) begin
                            r.serial = {w0, w1};
                        end
                    end else begin
                        if (dec_word0_ok) begin
                            prod = 21875 * int'(w0);
                            t = int'(prod >> 13) - 45000;
                            t = t / 100;
                            r.temp = t[TEMP_W-1:0];
                        end
                        if (word1_ok) begin
                            prod = 15625 * int'(w1);
                            h = int'(prod >> 13) - 6000;
                            h = h / 100;
                            if (h < 0) begin
                                h = 0;
                            end else if (h > 1000) begin
                                h = 1000;
                            end
                            r.hum = h[HUM_W-1:0];
                        end
                    end
                    expected_frames.push_back(r);
                end
            endcase
        end
    endtask

    function automatic t_reply_beat random_beat(input logic err);
        t_reply_beat b;
        b.data_byte = BYTE_W'($urandom);
        b.mode      = 1'($urandom);
        b.bus_error = err;
        return b;
    endfunction

    // Queue a full six-byte reply; mode only matters on the first byte
    task automatic add_frame(input logic md, input logic [WORD_W-1:0] w0,
                             input logic [WORD_W-1:0] w1, input bit bad0, input bit bad1);
        logic [BYTE_W-1:0] c0;
        logic [BYTE_W-1:0] c1;
        t_reply_beat b;
        c0 = crc8_fold(crc8_fold(CRC_INIT, w0[15:8]), w0[7:0]);
        c1 = crc8_fold(crc8_fold(CRC_INIT, w1[15:8]), w1[7:0]);
        if (bad0) c0 = c0 ^ BYTE_W'($urandom_range(1, 255));
        if (bad1) c1 = c1 ^ BYTE_W'($urandom_range(1, 255));
        b = random_beat(1'b0);
        b.mode = md;
        b.data_byte = w0[15:8];
        byte_q.push_back(b);
        b = random_beat(1'b0); b.data_byte = w0[7:0]; byte_q.push_back(b);
        b = random_beat(1'b0); b.data_byte = c0;      byte_q.push_back(b);
        b = random_beat(1'b0); b.data_byte = w1[15:8]; byte_q.push_back(b);
        b = random_beat(1'b0); b.data_byte = w1[7:0]; byte_q.push_back(b);
        b = random_beat(1'b0); b.data_byte = c1;      byte_q.push_back(b);
    endtask

    // Partial frame of n bytes cut short by a bus error
    task automatic add_abort(input int n);
        repeat (n) byte_q.push_back(random_beat(1'b0));
        byte_q.push_back(random_beat(1'b1));
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        return WORD_W'($urandom);
    endfunction

    // Driver: offer queued bytes, idle in bursts, predict on each accepted beat
    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid     <= 1'b0;
            quiet_tail      <= 1'b0;
            send_gap        = 0;
            dec_pos         = POS_W0_HI;
            dec_crc         = CRC_INIT;
            dec_word0_ok    = 1'b0;
            dec_serial_mode = 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                decode_beat(cur_beat);
            end
            quiet_tail <= (byte_q.size() <= TAIL_ITEMS);
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (byte_q.size() > 0) begin
                    cur_beat = byte_q.pop_front();
                    in_ch.valid     <= 1'b1;
                    in_ch.data_byte <= cur_beat.data_byte;
                    in_ch.mode      <= cur_beat.mode;
                    in_ch.bus_error <= cur_beat.bus_error;
                    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                        send_gap = $urandom_range(1, 16);
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off once, mid-run, so the pipeline backs up into the input
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: check each accepted frame, drive ready with random stall bursts
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            results_seen <= 0;
            recv_gap     = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_frames.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    want = expected_frames.pop_front();
                    if (out_ch.temperature_tenths !== want.temp)
                        report_mismatch($sformatf("temperature_tenths got %0d want %0d",
                            $signed(out_ch.temperature_tenths), $signed(want.temp)));
                    if (out_ch.humidity_tenths !== want.hum)
                        report_mismatch($sformatf("humidity_tenths got %0d want %0d",
                            out_ch.humidity_tenths, want.hum));
                    if (out_ch.serial_number !== want.serial)
                        report_mismatch($sformatf("serial_number got %08h want %08h",
                            out_ch.serial_number, want.serial));
                    if (out_ch.bus_failed !== want.bus_fail)
                        report_mismatch($sformatf("bus_failed got %b want %b",
                            out_ch.bus_failed, want.bus_fail));
                    if (out_ch.first_word_crc_bad !== want.crc0_bad)
                        report_mismatch($sformatf("first_word_crc_bad got %b want %b",
                            out_ch.first_word_crc_bad, want.crc0_bad));
                    if (out_ch.second_word_crc_bad !== want.crc1_bad)
                        report_mismatch($sformatf("second_word_crc_bad got %b want %b",
                            out_ch.second_word_crc_bad, want.crc1_bad));
                end
                results_seen <= results_seen + 1;
            end
            if (recv_gap > 0) begin
                recv_gap--;
                rdy = 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                recv_gap = $urandom_range(1, 16) - 1;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            out_ch.ready <= rdy && (hold_left == 0);
        end
    end

    // Watchdog
    always @(posedge clk) begin
        if (!rst_n) begin
            cycle_count <= 0;
        end else begin
            cycle_count <= cycle_count + 1;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.mode      = 1'b0;
        in_ch.bus_error = 1'b0;
        out_ch.ready    = 1'b0;

        // Directed: word extremes, clamp at both ends, truncation toward zero
        // just below zero degrees, crc failures on each word, serial frames,
        // bus error at the first byte and mid-frame
        add_frame(1'b0, 16'h0000, 16'hFFFF, 1'b0, 1'b0);
        add_frame(1'b0, 16'd16840, 16'h1234, 1'b0, 1'b1);
        add_frame(1'b0, 16'hFFFF, 16'h0000, 1'b1, 1'b0);
        add_frame(1'b1, 16'hFFFF, 16'h0000, 1'b0, 1'b0);
        add_abort(0);
        add_abort(2);
        add_frame(1'b1, 16'hA5A5, 16'h5A5A, 1'b1, 1'b0);

        // Random: mostly well-formed frames, some garbage frames and aborts
        while (byte_q.size() < STIM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: add_abort($urandom_range(0, 5));
                1: repeat (6) byte_q.push_back(random_beat(1'b0));
                default: add_frame(1'($urandom), pick_word(), pick_word(),
                                   $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0);
            endcase
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all bytes taken, all frames back, then a short quiet window
        while (byte_q.size() != 0 || in_ch.valid) @(posedge clk);
        while (expected_frames.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_frames.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/htfd_pkg.sv
hdl/htfd_if.sv
hdl/htfd_frame.sv
hdl/htfd_scale.sv
hdl/htfd_div.sv
hdl/humidity_temp_frame_decoder.sv
sim/humidity_temp_frame_decoder_tb.sv
